// ===== src/psvb_pkg.sv =====
// shared types and constants of the square voice bank
package psvb_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_ON    = 3'd1;
  localparam logic [2:0] CMD_TIMED = 3'd2;
  localparam logic [2:0] CMD_OFF   = 3'd3;
  localparam logic [2:0] CMD_ALL   = 3'd4;
  localparam logic [2:0] CMD_WHEEL = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_HOLD      = 3'd0;
  localparam logic [2:0] REG_RELEASE   = 3'd1;
  localparam logic [2:0] REG_MIN_LEVEL = 3'd2;
  localparam logic [2:0] REG_MAX_LEVEL = 3'd3;
  localparam logic [2:0] REG_LONG_HOLD = 3'd4;

  localparam logic [24:0] TTL_MAX   = 25'h1FFFFFF;
  localparam logic [7:0]  NOTE_NONE = 8'hff;
  localparam logic [16:0] VEL_FULL  = 17'h10000;
  localparam logic [19:0] BEND_UNITY = 20'h10000;
  localparam int          DIV_STEPS = 32;

  // one voice slot as held in the state memory
  typedef struct packed {
    logic [7:0]  note;
    logic [31:0] phase;
    logic [31:0] step;
    logic [31:0] base_step;
    logic [24:0] ttl;
    logic [24:0] ttl_start;
    logic [31:0] level;
    logic [31:0] fade_step;
  } voice_t;

endpackage

// ===== src/polyphonic_square_voice_bank_top.sv =====
// square-wave voice bank: sequencer over a voice state memory
//
// channel  | direction | handshake        | payload
// config   | in        | cfg_we           | cfg_addr, cfg_wdata
// command  | in        | start, busy      | cmd, note, velocity, duration_frames, phase_step, bend
// result   | out       | done (1 cycle)   | sample, accepted, live_voices
//
// tick, note off, release all and wheel sweep the voice memory one voice at a time,
// in three steps per voice (read, compute, write back).
// a note start walks the live flags one slot a cycle to the lowest free slot, then
// goes through multiply, sum, the bit-serial fade step divider and the slot write.
// synchronous reset clears live flags and memory valid flags at once; no clearing pass.
// busy stays high until the result strobe; the receiver cannot stall the result.
module polyphonic_square_voice_bank_top #(
  parameter int VOICES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [7:0]         note,
  input  logic [16:0]        velocity,
  input  logic [23:0]        duration_frames,
  input  logic [31:0]        phase_step,
  input  logic [19:0]        bend,
  output logic               done,
  output logic signed [21:0] sample,
  output logic               accepted,
  output logic [5:0]         live_voices
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICES - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SRCH = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_SWR  = 4'd5;
  localparam logic [3:0] ST_RD   = 4'd6;
  localparam logic [3:0] ST_EX   = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state;

  // configuration registers
  logic [21:0] hold_frames, release_frames;
  logic [15:0] min_level, max_level;
  logic [23:0] long_hold_frames;
  logic [19:0] current_bend;

  // captured item
  logic [2:0]  cmd_r;
  logic [7:0]  note_r;
  logic [16:0] vel_r;
  logic [23:0] dur_r;
  logic [31:0] step_r;

  // sequencer
  logic [IDX_W-1:0] idx;
  logic [VOICES-1:0] live_bits;
  logic [CNT_W-1:0] live_cnt;
  logic [21:0] acc_sum;
  logic        acc_flag;

  // memory and read path
  psvb_pkg::voice_t mem [VOICES];
  logic [VOICES-1:0] vld;
  psvb_pkg::voice_t rd_word, rv, ex_w, wb;
  logic rd_ok, ex_ok;

  // compute stage registers
  logic [24:0]        ex_dec;
  logic               ex_below, ex_le;
  logic [31:0]        ex_sub, ex_phase;
  logic [51:0]        ex_prod;
  logic signed [27:0] ex_hm;

  // note start datapath
  logic [32:0] p_lo, p_hi;
  logic [31:0] lev, bent;
  logic [24:0] ttl_new;
  logic [31:0] div_q;
  logic [21:0] div_r;
  logic [4:0]  div_cnt;

  logic [21:0] rel, hold;
  logic [16:0] vel_c;
  logic [23:0] dur_sel;
  logic [22:0] r_sh;
  logic [31:0] sat_prod;
  logic [27:0] rel_t;
  logic [24:0] rel_ttl;
  logic        wr_dead, wr_sound;
  logic [15:0] wr_amp;

  // effective register values
  assign rel  = (release_frames == '0) ? 22'd1 : release_frames;
  assign hold = (hold_frames == '0) ? 22'd1 : hold_frames;
  assign vel_c = (vel_r > psvb_pkg::VEL_FULL) ? psvb_pkg::VEL_FULL : vel_r;
  assign dur_sel = (cmd_r == psvb_pkg::CMD_ON) ? long_hold_frames : dur_r;
  assign r_sh = {div_r, div_q[31]};
  assign sat_prod = (ex_prod[51:48] != '0) ? 32'hFFFFFFFF : ex_prod[47:16];

  assign busy = (state != ST_IDLE);

  // never-written entries read as reset values
  always_comb begin
    rv = rd_word;
    if (!rd_ok) begin
      rv.note = psvb_pkg::NOTE_NONE;
      rv.ttl  = '0;
    end
  end

  // released ttl, saturated
  always_comb begin
    rel_t = (ex_hm > 28'sd0) ? ({6'b0, rel} + 28'(ex_hm)) : {6'b0, rel};
    rel_ttl = (rel_t > {3'b0, psvb_pkg::TTL_MAX}) ? psvb_pkg::TTL_MAX : rel_t[24:0];
  end

  // write-back word of a sweep
  always_comb begin
    wb = ex_w;
    wr_dead = 1'b0;
    wr_sound = 1'b0;
    unique case (cmd_r)
      psvb_pkg::CMD_TICK: begin
        if (ex_w.ttl != '0) begin
          if (ex_below && ex_le) begin
            wb.ttl = '0;
            wr_dead = 1'b1;
          end else begin
            wb.ttl = ex_dec;
            if (ex_below) wb.level = ex_sub;
            wb.phase = ex_phase;
            wr_dead = (ex_dec == '0);
            wr_sound = 1'b1;
          end
        end
      end
      psvb_pkg::CMD_OFF: begin
        if (ex_w.note == note_r) begin
          wb.note = psvb_pkg::NOTE_NONE;
          if (ex_w.ttl > {3'b0, rel}) wb.ttl = rel_ttl;
        end
      end
      psvb_pkg::CMD_ALL: begin
        wb.note = psvb_pkg::NOTE_NONE;
        if (ex_w.ttl >= {3'b0, rel}) wb.ttl = rel_ttl;
      end
      psvb_pkg::CMD_WHEEL: begin
        if (!ex_w.note[7]) wb.step = sat_prod;
      end
      default: ;
    endcase
  end

  assign wr_amp = wb.level[31:16];

  // voice state memory
  always_ff @(posedge clk) begin
    if (state == ST_RD) rd_word <= mem[idx];
    if (state == ST_WR && ex_ok) mem[idx] <= wb;
    if (state == ST_SWR) begin
      mem[idx] <= '{note: note_r, phase: 32'd0, step: bent, base_step: step_r,
                    ttl: ttl_new, ttl_start: ttl_new, level: lev, fade_step: div_q};
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    unique case (state)
      ST_EX: begin
        ex_w     <= rv;
        ex_ok    <= rd_ok;
        ex_dec   <= rv.ttl - 25'd1;
        ex_below <= (rv.ttl - 25'd1) < {3'b0, rel};
        ex_le    <= rv.level <= rv.fade_step;
        ex_sub   <= rv.level - rv.fade_step;
        ex_phase <= rv.phase + rv.step;
        ex_prod  <= rv.base_step * current_bend;
        ex_hm    <= $signed({6'b0, hold}) + $signed({3'b0, rv.ttl})
                    - $signed({3'b0, rv.ttl_start});
      end
      ST_MUL: begin
        p_lo    <= 33'(min_level * (psvb_pkg::VEL_FULL - vel_c));
        p_hi    <= 33'(max_level * vel_c);
        ex_prod <= step_r * current_bend;
      end
      ST_SUM: begin
        lev     <= 32'(p_lo + p_hi);
        div_q   <= 32'(p_lo + p_hi);
        div_r   <= '0;
        bent    <= sat_prod;
        ttl_new <= 25'(((dur_sel < {2'b0, hold}) ? {2'b0, hold} : dur_sel) + {2'b0, rel});
      end
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (r_sh >= {1'b0, rel}) begin
          div_r <= 22'(r_sh - {1'b0, rel});
          div_q <= {div_q[30:0], 1'b1};
        end else begin
          div_r <= r_sh[21:0];
          div_q <= {div_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // control: sequencer, registers, flags, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      hold_frames      <= 22'd4800;
      release_frames   <= 22'd4800;
      min_level        <= 16'd8192;
      max_level        <= 16'd65535;
      long_hold_frames <= 24'd240000;
      current_bend     <= psvb_pkg::BEND_UNITY;
      live_bits        <= '0;
      live_cnt         <= '0;
      vld              <= '0;
      rd_ok            <= 1'b0;
      idx              <= '0;
      div_cnt          <= '0;
      acc_sum          <= '0;
      acc_flag         <= 1'b0;
      done             <= 1'b0;
      sample           <= '0;
      accepted         <= 1'b0;
      live_voices      <= '0;
    end else begin
      done <= 1'b0;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          psvb_pkg::REG_HOLD:      hold_frames      <= cfg_wdata[21:0];
          psvb_pkg::REG_RELEASE:   release_frames   <= cfg_wdata[21:0];
          psvb_pkg::REG_MIN_LEVEL: min_level        <= cfg_wdata[15:0];
          psvb_pkg::REG_MAX_LEVEL: max_level        <= cfg_wdata[15:0];
          psvb_pkg::REG_LONG_HOLD: long_hold_frames <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            note_r   <= note;
            vel_r    <= velocity;
            dur_r    <= duration_frames;
            step_r   <= phase_step;
            acc_sum  <= '0;
            acc_flag <= 1'b0;
            idx      <= '0;
            unique case (cmd)
              psvb_pkg::CMD_TICK, psvb_pkg::CMD_OFF, psvb_pkg::CMD_ALL: state <= ST_RD;
              psvb_pkg::CMD_WHEEL: begin
                current_bend <= bend;
                state <= ST_RD;
              end
              psvb_pkg::CMD_ON, psvb_pkg::CMD_TIMED: begin
                state <= note[7] ? ST_DONE : ST_SRCH;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        // lowest free slot
        ST_SRCH: begin
          if (!live_bits[idx]) state <= ST_MUL;
          else if (idx == IDX_LAST) state <= ST_DONE;
          else idx <= idx + 1'b1;
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'(psvb_pkg::DIV_STEPS - 1)) state <= ST_SWR;
        end
        ST_SWR: begin
          vld[idx]       <= 1'b1;
          live_bits[idx] <= 1'b1;
          live_cnt       <= live_cnt + 1'b1;
          acc_flag       <= 1'b1;
          state          <= ST_DONE;
        end
        // sweep over voices
        ST_RD: begin
          rd_ok <= vld[idx];
          state <= ST_EX;
        end
        ST_EX: state <= ST_WR;
        ST_WR: begin
          if (ex_ok && wr_dead) begin
            live_bits[idx] <= 1'b0;
            live_cnt       <= live_cnt - 1'b1;
          end
          if (ex_ok && wr_sound) begin
            acc_sum <= wb.phase[31] ? (acc_sum + {6'b0, wr_amp})
                                    : (acc_sum - {6'b0, wr_amp});
          end
          if (idx == IDX_LAST) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          done        <= 1'b1;
          sample      <= acc_sum;
          accepted    <= acc_flag;
          live_voices <= 6'(live_cnt);
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result strobe only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // live count tracks the live flags
  a_live_cnt: assert property (@(posedge clk) disable iff (rst)
    live_cnt == CNT_W'($countones(live_bits)))
    else $error("live count out of step with live flags");

  // a start is only reported on a strobe
  a_acc_done: assert property (@(posedge clk) disable iff (rst)
    $rose(accepted) |-> done)
    else $error("accepted changed without a result");

  // a slot write always makes that slot live
  a_swr_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWR |=> live_bits[$past(idx)])
    else $error("started voice not live");

endmodule

// ===== sim/tb_polyphonic_square_voice_bank_top.sv =====
// self-checking testbench for the square voice bank: driver, monitor and predictor
`timescale 1ns / 1ps

module tb_polyphonic_square_voice_bank_top;

  localparam int NV = 32;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  note;
    logic [16:0] velocity;
    logic [23:0] duration_frames;
    logic [31:0] phase_step;
    logic [19:0] bend;
  } voice_cmd_t;

  typedef struct packed {
    logic signed [21:0] sample;
    logic               accepted;
    logic [5:0]         live_voices;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] cmd = '0;
  logic [7:0] note = '0;
  logic [16:0] velocity = '0;
  logic [23:0] duration_frames = '0;
  logic [31:0] phase_step = '0;
  logic [19:0] bend = '0;
  logic done;
  logic signed [21:0] sample;
  logic accepted;
  logic [5:0] live_voices;

  polyphonic_square_voice_bank_top #(.VOICES(NV)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .cmd(cmd), .note(note), .velocity(velocity),
    .duration_frames(duration_frames), .phase_step(phase_step), .bend(bend),
    .done(done), .sample(sample), .accepted(accepted), .live_voices(live_voices)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted bank state
  logic [21:0] hold_r, rel_r;
  logic [15:0] min_lvl, max_lvl;
  logic [23:0] long_hold_r;
  logic [7:0]  v_note [NV];
  logic [31:0] v_phase [NV], v_step [NV], v_base [NV], v_level [NV], v_fade [NV];
  logic [24:0] v_ttl [NV], v_ttl_start [NV];
  logic [19:0] cur_bend;

  voice_cmd_t    pending_cmds [$];
  frame_result_t expected_frames [$];
  int  mismatches = 0;
  bit  stim_done = 0;
  longint cycles = 0;

  function automatic logic [31:0] eff_hold();
    return (hold_r == 0) ? 32'd1 : 32'(hold_r);
  endfunction

  function automatic logic [31:0] eff_rel();
    return (rel_r == 0) ? 32'd1 : 32'(rel_r);
  endfunction

  function automatic logic [31:0] bend_step(logic [31:0] base);
    logic [63:0] p;
    p = (64'(base) * 64'(cur_bend)) >> 16;
    return (p > 64'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
  endfunction

  function automatic void reset_bank();
    hold_r = 4800; rel_r = 4800; min_lvl = 8192; max_lvl = 65535;
    long_hold_r = 240000; cur_bend = psvb_pkg::BEND_UNITY;
    for (int i = 0; i < NV; i++) begin
      v_note[i] = psvb_pkg::NOTE_NONE; v_ttl[i] = 0;
    end
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      psvb_pkg::REG_HOLD:      hold_r = val[21:0];
      psvb_pkg::REG_RELEASE:   rel_r = val[21:0];
      psvb_pkg::REG_MIN_LEVEL: min_lvl = val[15:0];
      psvb_pkg::REG_MAX_LEVEL: max_lvl = val[15:0];
      psvb_pkg::REG_LONG_HOLD: long_hold_r = val;
      default: ;
    endcase
  endfunction

  function automatic void release_slot(int i);
    longint elapsed, t;
    elapsed = longint'(v_ttl_start[i]) - longint'(v_ttl[i]);
    t = (elapsed < longint'(eff_hold())) ? longint'(eff_rel()) + longint'(eff_hold()) - elapsed
                                         : longint'(eff_rel());
    if (t > longint'(psvb_pkg::TTL_MAX)) t = longint'(psvb_pkg::TTL_MAX);
    v_ttl[i] = t[24:0];
  endfunction

  function automatic bit start_voice(logic [7:0] n, logic [16:0] vel, logic [23:0] dur,
                                     logic [31:0] st);
    int slot;
    logic [31:0] d, lev, v;
    slot = -1;
    if (n[7]) return 0;
    for (int i = 0; i < NV; i++)
      if (v_ttl[i] == 0) begin
        slot = i;
        break;
      end
    if (slot < 0) return 0;
    v = (vel > psvb_pkg::VEL_FULL) ? 32'(psvb_pkg::VEL_FULL) : 32'(vel);
    d = (32'(dur) < eff_hold()) ? eff_hold() : 32'(dur);
    d = d + eff_rel();
    lev = 32'(min_lvl) * (32'h10000 - v) + 32'(max_lvl) * v;
    v_phase[slot] = 0; v_note[slot] = n; v_base[slot] = st; v_step[slot] = bend_step(st);
    v_ttl[slot] = d[24:0]; v_ttl_start[slot] = d[24:0];
    v_level[slot] = lev; v_fade[slot] = lev / eff_rel();
    return 1;
  endfunction

  // expected result of one accepted item
  function automatic frame_result_t predict_frame(voice_cmd_t c);
    frame_result_t r;
    longint sum;
    int live;
    sum = 0; r = '0;
    case (c.cmd)
      psvb_pkg::CMD_TICK: begin
        for (int i = 0; i < NV; i++) begin
          if (v_ttl[i] == 0) continue;
          v_ttl[i] = v_ttl[i] - 25'd1;
          if (32'(v_ttl[i]) < eff_rel()) begin
            if (v_level[i] <= v_fade[i]) begin
              v_ttl[i] = 0;
              continue;
            end
            v_level[i] = v_level[i] - v_fade[i];
          end
          v_phase[i] = v_phase[i] + v_step[i];
          if (v_phase[i][31]) sum += longint'(v_level[i][31:16]);
          else sum -= longint'(v_level[i][31:16]);
        end
      end
      psvb_pkg::CMD_ON:
        r.accepted = start_voice(c.note, c.velocity, long_hold_r, c.phase_step);
      psvb_pkg::CMD_TIMED:
        r.accepted = start_voice(c.note, c.velocity, c.duration_frames, c.phase_step);
      psvb_pkg::CMD_OFF: begin
        for (int i = 0; i < NV; i++) begin
          if (v_note[i] != c.note) continue;
          v_note[i] = psvb_pkg::NOTE_NONE;
          if (32'(v_ttl[i]) > eff_rel()) release_slot(i);
        end
      end
      psvb_pkg::CMD_ALL: begin
        for (int i = 0; i < NV; i++) begin
          v_note[i] = psvb_pkg::NOTE_NONE;
          if (32'(v_ttl[i]) >= eff_rel()) release_slot(i);
        end
      end
      psvb_pkg::CMD_WHEEL: begin
        cur_bend = c.bend;
        for (int i = 0; i < NV; i++)
          if (!v_note[i][7]) v_step[i] = bend_step(v_base[i]);
      end
      default: ;
    endcase
    live = 0;
    for (int i = 0; i < NV; i++) if (v_ttl[i] != 0) live++;
    r.sample = sum[21:0];
    r.live_voices = live[5:0];
    return r;
  endfunction

  // driver: pops pending items with a random gap before each
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_frames.push_back(predict_frame({cmd, note, velocity, duration_frames,
                                                 phase_step, bend}));
        void'(pending_cmds.pop_front());
        gap_left <= $urandom_range(0, 8);
        start <= 1'b0;
      end else if (!start && pending_cmds.size() > 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else begin
          {cmd, note, velocity, duration_frames, phase_step, bend} <= pending_cmds[0];
          start <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    frame_result_t exp_r;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_frames.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_r = expected_frames.pop_front();
        if (exp_r !== {sample, accepted, live_voices}) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: exp sample %0d acc %0b live %0d, got %0d %0b %0d",
                     exp_r.sample, exp_r.accepted, exp_r.live_voices,
                     sample, accepted, live_voices);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("polyphonic_square_voice_bank_top: mismatch");
      $finish;
    end
  end

  function automatic voice_cmd_t rand_cmd(bit well_formed);
    voice_cmd_t c;
    int k;
    c.cmd = 3'($urandom_range(0, 7));
    if (well_formed) begin
      k = $urandom_range(0, 99);
      c.cmd = (k < 55) ? psvb_pkg::CMD_TICK : (k < 72) ? psvb_pkg::CMD_TIMED :
              (k < 78) ? psvb_pkg::CMD_ON : (k < 90) ? psvb_pkg::CMD_OFF :
              (k < 94) ? psvb_pkg::CMD_ALL : psvb_pkg::CMD_WHEEL;
    end
    c.note = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    c.velocity = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    c.duration_frames = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 40));
    c.phase_step = $urandom;
    c.bend = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(30000, 140000));
    return c;
  endfunction

  function automatic voice_cmd_t mk(logic [2:0] c, logic [7:0] n, logic [16:0] v,
                                    logic [23:0] d, logic [31:0] s, logic [19:0] b);
    return {c, n, v, d, s, b};
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_frames.size() > 0 || start) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    write_reg(idx, val);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd($urandom_range(0, 9) != 0));
    wait_idle();
  endtask

  initial begin
    reset_bank();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes and special cases at reset settings
    pending_cmds.push_back(mk(psvb_pkg::CMD_TIMED, 8'd5, 17'd0, 24'd0, 32'hFFFFFFFF, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_ON, 8'd6, 17'h1FFFF, 24'hFFFFFF, 32'h80000000,
                              20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_ON, 8'h85, 17'd65536, 24'd0, 32'd1, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_TICK, 8'hff, 17'h1FFFF, 24'hFFFFFF, 32'hFFFFFFFF,
                              20'hFFFFF));
    pending_cmds.push_back(mk(psvb_pkg::CMD_WHEEL, 8'd0, 17'd0, 24'd0, 32'd0, 20'hFFFFF));
    pending_cmds.push_back(mk(psvb_pkg::CMD_TICK, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_WHEEL, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_TICK, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(3'd6, 8'd5, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(3'd7, 8'd5, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_OFF, 8'd5, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_OFF, psvb_pkg::NOTE_NONE, 17'd0, 24'd0, 32'd0,
                              20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_ALL, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_TICK, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    wait_idle();
    // fill every free slot; the starts beyond that are dropped
    for (int i = 0; i < NV + 1; i++)
      pending_cmds.push_back(mk(psvb_pkg::CMD_TIMED, 8'(i % 3), 17'd40000, 24'd3,
                                32'h12345678, 20'd0));
    wait_idle();
    // short envelopes so voices end during the run
    cfg_write(psvb_pkg::REG_HOLD, 24'd0);
    cfg_write(psvb_pkg::REG_RELEASE, 24'd0);
    cfg_write(psvb_pkg::REG_MIN_LEVEL, 24'hFFFF);
    cfg_write(psvb_pkg::REG_MAX_LEVEL, 24'd0);
    cfg_write(psvb_pkg::REG_LONG_HOLD, 24'd0);
    run_random(150);
    cfg_write(psvb_pkg::REG_HOLD, 24'd6);
    cfg_write(psvb_pkg::REG_RELEASE, 24'd9);
    cfg_write(psvb_pkg::REG_MIN_LEVEL, 24'd0);
    cfg_write(psvb_pkg::REG_MAX_LEVEL, 24'hFFFF);
    cfg_write(psvb_pkg::REG_LONG_HOLD, 24'd20);
    run_random(200);
    // registers changed mid-note, set to their largest values
    pending_cmds.push_back(mk(psvb_pkg::CMD_ON, 8'd1, 17'd1000, 24'd0, 32'd77, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_TIMED, 8'd2, 17'd1000, 24'd5, 32'd77, 20'd0));
    wait_idle();
    cfg_write(psvb_pkg::REG_HOLD, 24'h3FFFFF);
    cfg_write(psvb_pkg::REG_RELEASE, 24'h3FFFFF);
    cfg_write(psvb_pkg::REG_LONG_HOLD, 24'hFFFFFF);
    pending_cmds.push_back(mk(psvb_pkg::CMD_OFF, 8'd1, 17'd0, 24'd0, 32'd0, 20'd0));
    pending_cmds.push_back(mk(psvb_pkg::CMD_ALL, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    wait_idle();
    run_random(100);
    cfg_write(psvb_pkg::REG_HOLD, 24'd3);
    cfg_write(psvb_pkg::REG_RELEASE, 24'd1);
    cfg_write(psvb_pkg::REG_MIN_LEVEL, 24'd1234);
    cfg_write(psvb_pkg::REG_MAX_LEVEL, 24'd50000);
    cfg_write(psvb_pkg::REG_LONG_HOLD, 24'd12);
    pending_cmds.push_back(mk(psvb_pkg::CMD_ALL, 8'd0, 17'd0, 24'd0, 32'd0, 20'd0));
    run_random(170);
    stim_done = 1;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0)
      $display("polyphonic_square_voice_bank_top: match");
    else
      $display("polyphonic_square_voice_bank_top: mismatch");
    $finish;
  end

endmodule
